// ===== rtl/core/png_scanline_unfilter_assert.svh =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter_assert.svh
// assertion macros for the unfilter rtl
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// same-cycle implication
`define PUS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("png_scanline_unfilter: same-cycle check failed");

// next-cycle implication
`define PUS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("png_scanline_unfilter: next-cycle check failed");

`endif

// ===== rtl/core/pus_pkg.sv =====
// ----------------------------------------------------------------------------
// pus_pkg
// constants, codes and types for the scanline unfilter
// ----------------------------------------------------------------------------
package pus_pkg;

  localparam int LINE_DEPTH = 8192;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int LEN_W      = 14;
  localparam int BPP_W      = 4;
  localparam int WIN_DEPTH  = 8;
  localparam int WIN_SEL_W  = $clog2(WIN_DEPTH);

  // filter type codes
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;
  localparam logic [7:0] FILT_LAST  = 8'd4;

  // register indexes
  localparam logic CFG_BPP = 1'b0;
  localparam logic CFG_LEN = 1'b1;

  typedef struct packed {
    logic                 shift;
    logic                 clear;
    logic [WIN_SEL_W-1:0] sel;
  } win_ctrl_t;

  typedef struct packed {
    logic [2:0] filter;
    logic       error;
  } pred_ctrl_t;

  typedef struct packed {
    logic              is_filter;
    logic              sof;
    logic              eol;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } s1_item_t;

endpackage

// ===== rtl/core/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// reverses png filter method 0 on a byte stream, line store in block memory
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_stall   | data_byte, start_of_image
//  out      | out_valid / out_stall | pixel_byte, end_of_line, bad_filter
//  cfg      | cfg_write             | cfg_index, cfg_data
//
// one word per cycle sustained while out_stall is low; for a data word the
// line store read is issued at accept, the predictor runs on the registered
// read data, and the result lands in the output register.
// filter-type words give no output word and take one slot in the pipe.
// reset clears control state only; the line store is not cleared and is
// masked on the first line of an image.
// out_stall backs up through one held stage to in_stall.
module png_scanline_unfilter
  import pus_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              start_of_image,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        pixel_byte,
  output logic              end_of_line,
  output logic              bad_filter,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [LEN_W-1:0]  cfg_data
);

  `include "png_scanline_unfilter_assert.svh"

  logic [BPP_W-1:0]  bytes_per_pixel;
  logic [LEN_W-1:0]  line_bytes;

  logic              awaiting;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] last_index;
  logic              in_accept;
  logic              to_filter;
  logic              rd_en;

  logic              s1_valid;
  s1_item_t          s1;
  s1_item_t          s1_next;
  logic              s1_adv;
  logic              out_free;

  logic [2:0]        line_filter;
  logic              first_line;
  logic              error_seen;

  logic [7:0]        rd_data;
  logic [7:0]        b_val;
  logic [7:0]        a_val;
  logic [7:0]        c_val;
  logic [7:0]        recon;
  logic              wr_en;
  win_ctrl_t         win_ctrl;
  pred_ctrl_t        pred_ctrl;
  logic [WIN_SEL_W-1:0] bpp_sel;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_W'(1);
      line_bytes      <= LEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BPP: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        CFG_LEN: line_bytes      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_bytes == '0) begin
      last_index = '0;
    end else if (line_bytes > LEN_W'(LINE_DEPTH)) begin
      last_index = ADDR_W'(LINE_DEPTH - 1);
    end else begin
      last_index = ADDR_W'(line_bytes - LEN_W'(1));
    end
    if (bytes_per_pixel == '0) begin
      bpp_sel = '0;
    end else if (bytes_per_pixel > BPP_W'(WIN_DEPTH)) begin
      bpp_sel = WIN_SEL_W'(WIN_DEPTH - 1);
    end else begin
      bpp_sel = WIN_SEL_W'(bytes_per_pixel - BPP_W'(1));
    end
  end

  // accept stage: line position and line store read
  assign out_free  = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && (s1.is_filter || out_free);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign to_filter = start_of_image || awaiting;
  assign rd_en     = in_accept && !to_filter;

  always_comb begin
    s1_next.is_filter = to_filter;
    s1_next.sof       = start_of_image;
    s1_next.eol       = !to_filter && (pos >= last_index);
    s1_next.addr      = pos;
    s1_next.data      = data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting <= 1'b1;
      pos      <= '0;
    end else if (in_accept) begin
      if (to_filter) begin
        awaiting <= 1'b0;
        pos      <= '0;
      end else if (s1_next.eol) begin
        awaiting <= 1'b1;
      end else begin
        pos <= pos + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1 <= s1_next;
    end
  end

  pus_line_store u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (pos),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1.addr),
    .wr_data (recon)
  );

  // reconstruct stage
  assign b_val = first_line ? 8'd0 : rd_data;
  assign wr_en = s1_adv && !s1.is_filter;

  always_comb begin
    win_ctrl.shift = wr_en;
    win_ctrl.clear = s1_adv && s1.is_filter;
    win_ctrl.sel   = bpp_sel;
    pred_ctrl.filter = line_filter;
    pred_ctrl.error  = error_seen;
  end

  pus_window u_window (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (win_ctrl),
    .left_in        (recon),
    .upper_in       (b_val),
    .left_tap       (a_val),
    .upper_left_tap (c_val)
  );

  pus_predictor u_pred (
    .ctrl  (pred_ctrl),
    .x     (s1.data),
    .a     (a_val),
    .b     (b_val),
    .c     (c_val),
    .recon (recon)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_filter <= FILT_NONE;
      first_line  <= 1'b1;
      error_seen  <= 1'b0;
    end else if (s1_adv) begin
      if (s1.is_filter) begin
        if (s1.sof) begin
          first_line <= 1'b1;
        end
        if (s1.data > FILT_LAST) begin
          error_seen <= 1'b1;
        end else begin
          line_filter <= s1.data[2:0];
          if (s1.sof) begin
            error_seen <= 1'b0;
          end
        end
      end else if (s1.eol) begin
        first_line <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pixel_byte  <= recon;
      end_of_line <= s1.eol;
      bad_filter  <= error_seen;
    end
  end

  `PUS_ASSERT_NOW(a_no_same_entry, clk, rst, rd_en && wr_en, pos != s1.addr)
  `PUS_ASSERT_NOW(a_error_zero, clk, rst, out_valid && bad_filter, pixel_byte == 8'd0)
  `PUS_ASSERT_NEXT(a_sof_first_line, clk, rst, s1_adv && s1.is_filter && s1.sof, first_line)
  `PUS_ASSERT_NEXT(a_eol_awaits, clk, rst, in_accept && s1_next.eol, awaiting)

endmodule

// ===== rtl/core/pus_line_store.sv =====
// ----------------------------------------------------------------------------
// pus_line_store
// single-port-read, single-port-write line memory, registered read data
// ----------------------------------------------------------------------------
module pus_line_store
  import pus_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data
);

  logic [7:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/pus_window.sv =====
// ----------------------------------------------------------------------------
// pus_window
// delay lines for the left and upper-left neighbours of the current byte
// ----------------------------------------------------------------------------
module pus_window
  import pus_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  win_ctrl_t ctrl,
  input  logic [7:0] left_in,
  input  logic [7:0] upper_in,
  output logic [7:0] left_tap,
  output logic [7:0] upper_left_tap
);

  logic [7:0] left_line  [WIN_DEPTH];
  logic [7:0] upper_line [WIN_DEPTH];

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        left_line[k]  <= '0;
        upper_line[k] <= '0;
      end
    end else if (ctrl.shift) begin
      for (int k = WIN_DEPTH - 1; k > 0; k--) begin
        left_line[k]  <= left_line[k-1];
        upper_line[k] <= upper_line[k-1];
      end
      left_line[0]  <= left_in;
      upper_line[0] <= upper_in;
    end
  end

  assign left_tap       = left_line[ctrl.sel];
  assign upper_left_tap = upper_line[ctrl.sel];

endmodule

// ===== rtl/core/pus_predictor.sv =====
// ----------------------------------------------------------------------------
// pus_predictor
// filter predictor (none, sub, up, average, paeth) and byte reconstruction
// ----------------------------------------------------------------------------
module pus_predictor
  import pus_pkg::*;
(
  input  pred_ctrl_t ctrl,
  input  logic [7:0] x,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] c,
  output logic [7:0] recon
);

  logic        [8:0]  avg_sum;
  logic signed [10:0] sa, sb, sc;
  logic signed [10:0] da, db, dc;
  logic        [9:0]  pa, pb, pc;
  logic        [7:0]  paeth;
  logic        [7:0]  pred;

  always_comb begin
    avg_sum = {1'b0, a} + {1'b0, b};
    sa = 11'(signed'({3'b000, a}));
    sb = 11'(signed'({3'b000, b}));
    sc = 11'(signed'({3'b000, c}));
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - (sc <<< 1);
    pa = da[10] ? 10'(-da) : da[9:0];
    pb = db[10] ? 10'(-db) : db[9:0];
    pc = dc[10] ? 10'(-dc) : dc[9:0];
    // ties go to a, then b
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
    case (ctrl.filter)
      FILT_NONE:  pred = '0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = '0;
    endcase
    recon = ctrl.error ? 8'd0 : x + pred;
  end

endmodule
